// ===== sv/cmq_pkg.sv =====
package cmq_pkg;

    localparam int PHI_W     = 16;
    localparam int QW_W      = 15;
    localparam int QV_W      = 16;
    localparam int Q_W       = 15;
    localparam int NUM_BITS  = 15;
    localparam int NUM_LANES = 4;
    localparam int NUM_VEC   = 3;
    localparam int MAG_W     = 16;
    localparam int SQ_W      = 32;
    localparam int S_W       = 32;
    localparam int U_W       = 48;
    localparam int D_W       = 64;

    localparam logic [Q_W-1:0] Q_MAX = 15'd16384;

    // Lane order inside a stage: the scalar part first, then the vector parts.
    localparam int LANE_W = 0;
    localparam int LANE_X = 1;
    localparam int LANE_Y = 2;
    localparam int LANE_Z = 3;

    // One square-root search: residual d = num - (2q-1)^2 * s and u = (2q-1) * s.
    typedef struct packed {
        logic signed [D_W-1:0] d;
        logic signed [U_W-1:0] u;
        logic [Q_W-1:0]        q;
    } t_lane;

    typedef struct packed {
        t_lane [NUM_LANES-1:0] lane;
        logic [S_W-1:0]        s;
        logic [NUM_VEC-1:0]    neg;
    } t_stage;

endpackage

// ===== sv/cmq_if.sv =====
interface cmq_in_if;
    logic                             valid;
    logic                             ready;
    logic signed [cmq_pkg::PHI_W-1:0] phi_x;
    logic signed [cmq_pkg::PHI_W-1:0] phi_y;
    logic signed [cmq_pkg::PHI_W-1:0] phi_z;

    modport source (output valid, output phi_x, output phi_y, output phi_z, input ready);
    modport sink (input valid, input phi_x, input phi_y, input phi_z, output ready);
endinterface

interface cmq_out_if;
    logic                            valid;
    logic                            ready;
    logic        [cmq_pkg::QW_W-1:0] quat_w;
    logic signed [cmq_pkg::QV_W-1:0] quat_x;
    logic signed [cmq_pkg::QV_W-1:0] quat_y;
    logic signed [cmq_pkg::QV_W-1:0] quat_z;

    modport source (output valid, output quat_w, output quat_x, output quat_y,
                    output quat_z, input ready);
    modport sink (input valid, input quat_w, input quat_x, input quat_y,
                  input quat_z, output ready);
endinterface

// ===== sv/cmq_prep.sv =====
module cmq_prep (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic signed [cmq_pkg::PHI_W-1:0] i_phi_x,
    input  logic signed [cmq_pkg::PHI_W-1:0] i_phi_y,
    input  logic signed [cmq_pkg::PHI_W-1:0] i_phi_z,
    output logic                             o_valid,
    input  logic                             i_ready,
    output cmq_pkg::t_stage                  o_data
);
    import cmq_pkg::*;

    logic [PHI_W-1:0]   phi [NUM_VEC];
    logic [MAG_W-1:0]   mag [NUM_VEC];
    logic [NUM_VEC-1:0] sgn;

    logic               r_v1;
    logic [SQ_W-1:0]    r_sq [NUM_VEC];
    logic [NUM_VEC-1:0] r_neg;
    logic               rdy1;

    logic               r_v2;
    t_stage             r_data;
    t_stage             n_data;
    logic               rdy2;
    logic [S_W-1:0]     s_sum;
    logic signed [D_W-1:0] s_ext;

    assign phi[0] = i_phi_x;
    assign phi[1] = i_phi_y;
    assign phi[2] = i_phi_z;

    always_comb begin
        for (int i = 0; i < NUM_VEC; i++) begin
            sgn[i] = phi[i][PHI_W-1];
            mag[i] = sgn[i] ? MAG_W'(~phi[i] + 1'b1) : MAG_W'(phi[i]);
        end
    end

    assign rdy2    = !r_v2 || i_ready;
    assign rdy1    = !r_v1 || rdy2;
    assign o_ready = rdy1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (rdy1) begin
            r_v1 <= i_valid;
        end
        if (rdy1 && i_valid) begin
            for (int i = 0; i < NUM_VEC; i++) begin
                r_sq[i] <= mag[i] * mag[i];
            end
            r_neg <= sgn;
        end
    end

    // s = 2^24 + sum of squares; the scalar lane compares against 2^54 and the
    // vector lanes against a^2 * 2^30. The search starts from q = 0, so t = -1.
    assign s_sum = S_W'(32'd16777216) + r_sq[0] + r_sq[1] + r_sq[2];
    assign s_ext = $signed({{(D_W-S_W){1'b0}}, s_sum});

    always_comb begin
        n_data     = r_data;
        n_data.s   = s_sum;
        n_data.neg = r_neg;
        n_data.lane[LANE_W].d = $signed(D_W'(64'd1) << 54) - s_ext;
        for (int i = 0; i < NUM_VEC; i++) begin
            n_data.lane[LANE_X+i].d =
                $signed({{(D_W-SQ_W-30){1'b0}}, r_sq[i], 30'd0}) - s_ext;
        end
        for (int l = 0; l < NUM_LANES; l++) begin
            n_data.lane[l].u = -$signed({{(U_W-S_W){1'b0}}, s_sum});
            n_data.lane[l].q = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (rdy2) begin
            r_v2 <= r_v1;
        end
        if (rdy2 && r_v1) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_v2;
    assign o_data  = r_data;

endmodule

// ===== sv/cmq_cell.sv =====
module cmq_cell #(
    parameter int BIT = 0
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  cmq_pkg::t_stage i_data,
    output logic            o_valid,
    input  logic            i_ready,
    output cmq_pkg::t_stage o_data
);
    import cmq_pkg::*;

    localparam logic [Q_W-1:0] CAND_BIT = Q_W'(1) << BIT;

    logic                  r_valid;
    t_stage                r_data;
    t_stage                n_data;

    logic signed [D_W-1:0] s_ext;
    logic signed [U_W-1:0] s_u;
    logic [Q_W-1:0]        cand  [NUM_LANES];
    logic signed [D_W-1:0] u_ext [NUM_LANES];
    logic signed [D_W-1:0] step  [NUM_LANES];
    logic signed [D_W-1:0] trial [NUM_LANES];
    logic                  take  [NUM_LANES];

    assign s_ext = $signed({{(D_W-S_W){1'b0}}, i_data.s});
    assign s_u   = $signed({{(U_W-S_W){1'b0}}, i_data.s});

    // Setting bit BIT moves t = 2q-1 up by 2^(BIT+1), so t^2 * s grows by
    // 2^(BIT+2) * u + 2^(2*BIT+2) * s, and u grows by 2^(BIT+1) * s.
    always_comb begin
        n_data = i_data;
        for (int l = 0; l < NUM_LANES; l++) begin
            cand[l]  = i_data.lane[l].q | CAND_BIT;
            u_ext[l] = {{(D_W-U_W){i_data.lane[l].u[U_W-1]}}, i_data.lane[l].u};
            step[l]  = (u_ext[l] <<< (BIT + 2)) + (s_ext <<< (2 * BIT + 2));
            trial[l] = i_data.lane[l].d - step[l];
            take[l]  = (cand[l] <= Q_MAX) && !trial[l][D_W-1];
            if (take[l]) begin
                n_data.lane[l].d = trial[l];
                n_data.lane[l].u = i_data.lane[l].u + (s_u <<< (BIT + 1));
                n_data.lane[l].q = cand[l];
            end
        end
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// ===== sv/cayley_map_to_quaternion_unit.sv =====
// Channel   Direction  Payload                          Transaction
// i_phi     in         phi_x, phi_y, phi_z (Q4.12)      valid & ready
// o_quat    out        quat_w (Q1.14), quat_x..z (Q2.14) valid & ready
//
// One transaction enters per cycle while the output is not stalled: the
// prep block first registers the squares, then the residuals, then a row of
// 15 cells decides one result bit each, for all four components at once.
// Reset clears every stage valid bit; the data registers are not reset.
// A stall at the output fills the stages behind it one by one; a stage with
// no transaction in it keeps accepting, so bubbles close up.
module cayley_map_to_quaternion_unit (
    input logic      i_clk,
    input logic      i_rst_n,
    cmq_in_if.sink   i_phi,
    cmq_out_if.source o_quat
);
    import cmq_pkg::*;

    logic   valid [NUM_BITS+1];
    logic   ready [NUM_BITS+1];
    t_stage data  [NUM_BITS+1];
    t_stage last;

    cmq_prep u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_phi.valid),
        .o_ready (i_phi.ready),
        .i_phi_x (i_phi.phi_x),
        .i_phi_y (i_phi.phi_y),
        .i_phi_z (i_phi.phi_z),
        .o_valid (valid[0]),
        .i_ready (ready[0]),
        .o_data  (data[0])
    );

    for (genvar k = 0; k < NUM_BITS; k++) begin : g_cell
        cmq_cell #(
            .BIT (NUM_BITS - 1 - k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (valid[k]),
            .o_ready (ready[k]),
            .i_data  (data[k]),
            .o_valid (valid[k+1]),
            .i_ready (ready[k+1]),
            .o_data  (data[k+1])
        );
    end

    assign last              = data[NUM_BITS];
    assign ready[NUM_BITS]   = o_quat.ready;
    assign o_quat.valid      = valid[NUM_BITS];
    assign o_quat.quat_w     = last.lane[LANE_W].q;
    assign o_quat.quat_x     = last.neg[0] ? -$signed({1'b0, last.lane[LANE_X].q})
                                           : $signed({1'b0, last.lane[LANE_X].q});
    assign o_quat.quat_y     = last.neg[1] ? -$signed({1'b0, last.lane[LANE_Y].q})
                                           : $signed({1'b0, last.lane[LANE_Y].q});
    assign o_quat.quat_z     = last.neg[2] ? -$signed({1'b0, last.lane[LANE_Z].q})
                                           : $signed({1'b0, last.lane[LANE_Z].q});

    // Since |phi| is bounded, the scalar part never drops to zero.
    a_w_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_quat.valid |-> o_quat.quat_w != '0)
        else $error("scalar part of the quaternion is zero");

    a_x_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_quat.valid |-> (o_quat.quat_x >= -16'sd16384) && (o_quat.quat_x <= 16'sd16384))
        else $error("quat_x out of range");

    // With the output taken, every stage can move, so the input must be open.
    a_ready_chain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_quat.ready |-> i_phi.ready)
        else $error("input blocked while the output is ready");

endmodule
